// File: hdl/bslm_pkg.sv
`default_nettype none
package bslm_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC     = 2'd0,
    MODE_COMPLETE  = 2'd1,
    MODE_RECREATE  = 2'd2,
    MODE_OPEN_ACK  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    STAT_GRANTED      = 4'd0,
    STAT_NONE_FREE    = 4'd1,
    STAT_OPEN_PENDING = 4'd2,
    STAT_COMPLETED    = 4'd3,
    STAT_STALE        = 4'd4,
    STAT_OUTDATED     = 4'd5,
    STAT_BAD_INDEX    = 4'd6,
    STAT_RECREATED    = 4'd7,
    STAT_OPEN_ACKED   = 4'd8,
    STAT_NOT_PENDING  = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic sweep;
    logic search;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic alloc_go;
    logic search_done;
    logic out_free;
  } sts_t;

  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
  localparam int          SLOT_W        = 4;
  localparam int          SEQ_W         = 64;
  localparam int          TICK_W        = 32;
  localparam int          IN_DATA_W     = 104;
  localparam int          OUT_DATA_W    = 72;

endpackage
`default_nettype wire

// File: hdl/bslm_ctrl.sv
`default_nettype none
module bslm_ctrl
  import bslm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.alloc_go ? S_SEARCH : S_DONE;
      end
      S_SEARCH: begin
        if (sts.search_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      S_EXEC: begin
        cmd.sweep = sts.alloc_go;
        cmd.exec  = !sts.alloc_go;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/bslm_dp.sv
`default_nettype none
module bslm_dp
  import bslm_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic [IN_DATA_W-1:0]    s_tdata,
  input  wire logic [1:0]              s_tuser,
  input  wire logic [TICK_W-1:0]       timeout,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OUT_DATA_W-1:0]        m_tdata,
  output logic [3:0]                   m_tuser
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic              leased    [SLOTS];
  logic [SEQ_W-1:0]  seqs      [SLOTS];
  logic [TICK_W-1:0] start     [SLOTS];
  logic [IW-1:0]     next_index;
  logic              open_pending;
  logic              reopen_flag;

  mode_t             mode_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [TICK_W-1:0] now_q;

  logic [IW-1:0]     sidx;
  logic [IW-1:0]     scount;

  status_t           res_status;
  logic [IW-1:0]     res_slot;
  logic [SEQ_W-1:0]  res_seq;

  status_t           out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [SEQ_W-1:0]  out_seq;
  logic              out_reopen;

  logic              slot_ok;
  logic [IW-1:0]     rd_idx;
  logic              rd_leased;
  logic [SEQ_W-1:0]  rd_seq;
  logic              seq_older;
  logic [IW-1:0]     sidx_inc;
  logic              expired [SLOTS];
  logic              any_expired;

  always_comb begin
    slot_ok   = {1'b0, slot_q} < (SLOT_W + 1)'(SLOTS);
    rd_idx    = (mode_q == MODE_COMPLETE) ? slot_q[IW-1:0] : sidx;
    rd_leased = leased[rd_idx];
    rd_seq    = seqs[rd_idx];
    seq_older = rd_seq >= seq_q;
    sidx_inc  = (sidx == LAST_IDX) ? '0 : sidx + IW'(1);
    any_expired = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      expired[i] = leased[i] && ((now_q - start[i]) > timeout);
      any_expired = any_expired || expired[i];
    end
  end

  always_comb begin
    sts.alloc_go    = (mode_q == MODE_ALLOC) && !open_pending;
    sts.search_done = !rd_leased || (scount == LAST_IDX);
    sts.out_free    = !m_tvalid || m_tready;
  end

  // slot state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        leased[i] <= 1'b0;
        seqs[i]   <= '0;
        start[i]  <= '0;
      end
      next_index   <= '0;
      open_pending <= 1'b0;
      reopen_flag  <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (expired[i]) begin
            leased[i]   <= 1'b0;
            start[i]    <= '0;
          end
        end
        if (any_expired) reopen_flag <= 1'b1;
      end
      if (cmd.search && !rd_leased) begin
        leased[sidx] <= 1'b1;
        start[sidx]  <= now_q;
        next_index   <= sidx_inc;
      end
      if (cmd.exec) begin
        case (mode_q)
          MODE_COMPLETE: begin
            if (slot_ok && rd_leased) begin
              leased[rd_idx] <= 1'b0;
              start[rd_idx]  <= '0;
              if (!seq_older) seqs[rd_idx] <= seq_q + SEQ_W'(1);
            end
          end
          MODE_RECREATE: begin
            for (int i = 0; i < SLOTS; i++) begin
              leased[i] <= 1'b0;
              seqs[i]   <= '0;
              start[i]  <= '0;
            end
            next_index   <= '0;
            open_pending <= 1'b1;
            reopen_flag  <= 1'b0;
          end
          MODE_OPEN_ACK: begin
            open_pending <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // transaction latch, search walk and result
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q <= mode_t'(s_tuser);
      slot_q <= s_tdata[SLOT_W-1:0];
      seq_q  <= s_tdata[SLOT_W +: SEQ_W];
      now_q  <= s_tdata[SLOT_W + SEQ_W +: TICK_W];
    end
    if (cmd.sweep) begin
      sidx   <= next_index;
      scount <= '0;
    end
    if (cmd.search) begin
      if (!rd_leased) begin
        res_status <= STAT_GRANTED;
        res_slot   <= sidx;
        res_seq    <= rd_seq;
      end else if (scount == LAST_IDX) begin
        res_status <= STAT_NONE_FREE;
        res_slot   <= '0;
        res_seq    <= '0;
      end else begin
        sidx   <= sidx_inc;
        scount <= scount + IW'(1);
      end
    end
    if (cmd.exec) begin
      res_slot <= '0;
      res_seq  <= '0;
      case (mode_q)
        MODE_ALLOC: res_status <= STAT_OPEN_PENDING;
        MODE_COMPLETE: begin
          if (!slot_ok)       res_status <= STAT_BAD_INDEX;
          else if (!rd_leased) res_status <= STAT_STALE;
          else if (seq_older)  res_status <= STAT_OUTDATED;
          else                 res_status <= STAT_COMPLETED;
        end
        MODE_RECREATE: res_status <= STAT_RECREATED;
        MODE_OPEN_ACK: res_status <= open_pending ? STAT_OPEN_ACKED : STAT_NOT_PENDING;
        default:       res_status <= STAT_NOT_PENDING;
      endcase
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_slot   <= SLOT_W'(res_slot);
      out_seq    <= res_seq;
      out_reopen <= reopen_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_reopen, out_seq, out_slot};

endmodule
`default_nettype wire

// File: hdl/buffer_slot_lease_manager_unit.sv
// Buffer slot lease manager.
// Input stream (s_*): one request transaction per item; s_tuser carries the
// request mode (allocate, completion, recreate, open acknowledge), s_tdata
// the slot index, returned sequence value and current tick count.
// Output stream (m_*): exactly one response transaction per request;
// m_tuser carries the status code, m_tdata the granted slot, its sequence
// value and the reopen request flag.
// APB port: register 0 at address 0 is the lease timeout in ticks.
// Sequencing: completion, recreate, open acknowledge and a blocked allocate
// go from acceptance through the execute state to the output load. An
// allocate runs the parallel timeout sweep, then the round-robin search
// probes slots in turn until a free one is found or all were probed, then
// loads the output. One request is in work at a time.
// The output register holds a finished response while the sink stalls and
// the next request is accepted meanwhile; its result waits until the
// output register frees.
// Reset (synchronous, rst high) frees all slots, zeroes sequences, stamps
// and the search index, clears open-pending and reopen, timeout = 5000.
`default_nettype none
module buffer_slot_lease_manager_unit
  import bslm_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // slot[3:0], seq_value[67:4], now_ticks[99:68]
  input  wire logic [1:0]            s_tuser,   // mode[1:0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // granted_slot[3:0], slot_seq[67:4], reopen_request[68]
  output logic [3:0]                 m_tuser,   // status[3:0]
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [TICK_W-1:0] timeout;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      timeout <= pwdata;
    end
  end

  assign prdata = paddr[2] ? 32'd0 : timeout;

  bslm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bslm_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .timeout  (timeout),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire
